// ===== rtl/upd_pkg.sv =====
// Shared types, character codes and decode helpers for the URL percent decoder.
// No dependencies; used by the decoder, queue and top level.
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_FIRST = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} dec_out_t;

	typedef struct packed {
		phase_t phase;
	} dec_stat_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           room;
	} q_stat_t;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [7:0] plain(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	// strtol base 16 on two characters, low 8 bits
	function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
		logic [4:0] h1;
		logic [4:0] h2;
		logic [7:0] r;
		h1 = hex_val(c1);
		h2 = hex_val(c2);
		r  = 8'd0;
		if (h1[4]) begin
			r = h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
		end else if (is_blank(c1) || c1 == CH_PLUS) begin
			r = h2[4] ? {4'd0, h2[3:0]} : 8'd0;
		end else if (c1 == CH_MINUS) begin
			r = h2[4] ? (8'd0 - {4'd0, h2[3:0]}) : 8'd0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/upd_if.sv =====
// Stream interfaces for the raw byte input and the decoded byte output.
// Standalone; valid/ready handshake with payload.
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source(output valid, in_byte, in_last, input ready);
	modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source(output valid, out_byte, out_last, input ready);
	modport sink(input valid, out_byte, out_last, output ready);
endinterface

// ===== rtl/url_percent_decoder_core.sv =====
// Top level of the streaming URL percent decoder.
// Depends on upd_pkg, upd_if, upd_decode and upd_queue.
//
// Usage:
//   rx carries raw message bytes (in_byte, in_last marks the final byte);
//   tx carries decoded bytes (out_byte, out_last). Both use valid/ready,
//   a request moves on a clock edge with both high.
//   '+' becomes a space, "%XY" becomes one byte, a '%' cut short by the end
//   of the message is passed on literally.
//   A result is written into the result queue on the edge that takes the
//   request completing it. Throughput: one request per cycle while rx.ready
//   is high; a request that ends a message right after '%' gives two results,
//   drained one per cycle while tx.ready is high. The rate is set by the
//   four-entry result queue: rx.ready is high while it has room for two results.
//   Reset clears the escape state and empties the queue.
//   When tx stalls the queue fills and rx.ready drops; nothing is lost.
module url_percent_decoder_core import upd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    rx,
	upd_out_if.source tx
);

	logic      accept;
	dec_out_t  res;
	dec_stat_t dstat;
	q_stat_t   qstat;

	assign rx.ready = qstat.room;
	assign accept   = rx.valid && rx.ready;

	upd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (rx.in_byte),
		.in_last (rx.in_last),
		.res     (res),
		.stat    (dstat)
	);

	upd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.stat   (qstat),
		.tx     (tx)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCW'(QDEPTH))
		else $error("result queue overflow");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid == (qstat.count != '0))
		else $error("tx valid out of step with queue fill");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx.in_last |=> dstat.phase == PH_IDLE)
		else $error("escape pending across message end");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.count != 2'd0 |-> qstat.count <= QCW'(QDEPTH - 2))
		else $error("results pushed without room");

endmodule

// ===== rtl/upd_decode.sv =====
// Escape tracking state and per-byte decode, producing zero to two results.
// Depends on upd_pkg.
module upd_decode import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output dec_out_t   res,
	output dec_stat_t  stat
);

	phase_t     phase_q, phase_d;
	logic [7:0] first_q, first_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= 8'd0;
		end else begin
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		first_d   = first_q;
		res.count = 2'd0;
		res.r0    = '0;
		res.r1    = '0;
		if (accept) begin
			case (phase_q)
				PH_PCT: begin
					if (in_last) begin
						phase_d   = PH_IDLE;
						res.count = 2'd2;
						res.r0    = '{data: CH_PERCENT, last: 1'b0};
						res.r1    = '{data: plain(in_byte), last: 1'b1};
					end else begin
						first_d = in_byte;
						phase_d = PH_FIRST;
					end
				end
				PH_FIRST: begin
					phase_d   = PH_IDLE;
					res.count = 2'd1;
					res.r0    = '{data: decode_pair(first_q, in_byte), last: in_last};
				end
				default: begin
					phase_d = PH_IDLE;
					if (in_byte == CH_PERCENT && !in_last) begin
						phase_d = PH_PCT;
					end else begin
						res.count = 2'd1;
						res.r0    = '{data: plain(in_byte), last: in_last};
					end
				end
			endcase
		end
	end

	assign stat.phase = phase_q;

endmodule

// ===== rtl/upd_queue.sv =====
// Result queue: takes up to two decoded bytes a cycle, drives the output stream.
// Depends on upd_pkg and upd_out_if.
module upd_queue import upd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dec_out_t  res,
	output q_stat_t   stat,
	upd_out_if.source tx
);

	result_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] count_q;
	logic           pop;
	logic [QAW-1:0] wr_next;

	assign pop     = tx.valid && tx.ready;
	assign wr_next = wr_q + QAW'(1);

	always_ff @(posedge clk) begin
		if (res.count != 2'd0) begin
			mem_q[wr_q] <= res.r0;
		end
		if (res.count == 2'd2) begin
			mem_q[wr_next] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(res.count);
			rd_q    <= rd_q + QAW'(pop);
			count_q <= count_q + QCW'(res.count) - QCW'(pop);
		end
	end

	assign tx.valid    = (count_q != '0);
	assign tx.out_byte = mem_q[rd_q].data;
	assign tx.out_last = mem_q[rd_q].last;

	// room for two results regardless of this cycle's pop
	assign stat.count = count_q;
	assign stat.room  = (count_q <= QCW'(QDEPTH - 2));

endmodule

// ===== tb/sv/upd_decode_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for url_percent_decoder_core: watches the rx and tx channels,
// predicts the decoded bytes from each rx request and checks them on tx.
// Depends on upd_pkg.
module upd_decode_checker import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  logic       rx_last,
	input  logic       tx_valid,
	input  logic       tx_ready,
	input  logic [7:0] tx_byte,
	input  logic       tx_last,
	output int         fail_count,
	output int         pending
);

	phase_t     esc_phase;
	logic [7:0] esc_char;
	result_t    decoded_q[$];
	result_t    want;

	// bit 4 flags a hex digit, bits 3:0 hold its value
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) begin
			return {1'b1, c[3:0]};
		end
		if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			return {1'b1, c[3:0] + 4'd9};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] plus_to_space(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	task automatic add_expected(input logic [7:0] d, input logic l);
		result_t r;
		r.data = d;
		r.last = l;
		decoded_q.insert(decoded_q.size(), r);
	endtask

	task automatic predict_decode(input logic [7:0] b, input logic l);
		logic [4:0] h1;
		logic [4:0] h2;
		logic [7:0] v;
		case (esc_phase)
			PH_PCT: begin
				if (l) begin
					add_expected(CH_PERCENT, 1'b0);
					add_expected(plus_to_space(b), 1'b1);
					esc_phase = PH_IDLE;
				end else begin
					esc_char  = b;
					esc_phase = PH_FIRST;
				end
			end
			PH_FIRST: begin
				// strtol base 16 on two characters, low byte kept
				h1 = hex_nibble(esc_char);
				h2 = hex_nibble(b);
				if (h1[4]) begin
					v = h2[4] ? {h1[3:0], h2[3:0]} : {4'h0, h1[3:0]};
				end else if (esc_char == CH_SPACE || (esc_char >= CH_TAB && esc_char <= CH_CR)
						|| esc_char == CH_PLUS) begin
					v = h2[4] ? {4'h0, h2[3:0]} : 8'h00;
				end else if (esc_char == CH_MINUS) begin
					v = h2[4] ? 8'h00 - {4'h0, h2[3:0]} : 8'h00;
				end else begin
					v = 8'h00;
				end
				add_expected(v, l);
				esc_phase = PH_IDLE;
			end
			default: begin
				esc_phase = PH_IDLE;
				if (b == CH_PERCENT && !l) begin
					esc_phase = PH_PCT;
				end else begin
					add_expected(plus_to_space(b), l);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_phase  = PH_IDLE;
			esc_char   = 8'h00;
			decoded_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (rx_valid && rx_ready) begin
				predict_decode(rx_byte, rx_last);
			end
			if (tx_valid && tx_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected byte: expected none, got %02h last %0b",
						$time, tx_byte, tx_last);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					if (want.data !== tx_byte) begin
						$display("%0t: out_byte mismatch: expected %02h, got %02h",
							$time, want.data, tx_byte);
						fail_count++;
					end
					if (want.last !== tx_last) begin
						$display("%0t: out_last mismatch: expected %0b, got %0b",
							$time, want.last, tx_last);
						fail_count++;
					end
				end
			end
			pending = decoded_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_url_percent_decoder_core.sv =====
`timescale 1ns / 100ps
// Top of the url_percent_decoder_core testbench: clock, reset, request
// stimulus and verdict. Depends on upd_pkg, upd_if and upd_decode_checker.
module tb_url_percent_decoder_core;
	import upd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1900;

	logic clk;
	logic arst_n;
	logic stall_en;
	int   fail_count;
	int   pending;
	int   items_sent;

	upd_in_if  rx();
	upd_out_if tx();

	url_percent_decoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.tx     (tx)
	);

	upd_decode_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx.valid),
		.rx_ready   (rx.ready),
		.rx_byte    (rx.in_byte),
		.rx_last    (rx.in_last),
		.tx_valid   (tx.valid),
		.tx_ready   (tx.ready),
		.tx_byte    (tx.out_byte),
		.tx_last    (tx.out_last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		tx.ready <= arst_n && (!stall_en || $urandom_range(0, 99) >= 25);
	end

	// called at a falling edge, returns at a falling edge
	task automatic push_byte(input logic [7:0] b, input logic l);
		while (stall_en && $urandom_range(0, 99) < 25) begin
			rx.valid <= 1'b0;
			@(negedge clk);
		end
		rx.valid   <= 1'b1;
		rx.in_byte <= b;
		rx.in_last <= l;
		@(posedge clk);
		while (!rx.ready) begin
			@(posedge clk);
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			push_byte(s[i], i == s.len() - 1);
		end
	endtask

	function automatic logic [7:0] escape_char();
		string hex_set;
		hex_set = "0123456789abcdefABCDEF";
		case ($urandom_range(0, 7))
			0, 1, 2: return hex_set[$urandom_range(0, 21)];
			3:       return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
			4:       return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
			5:       return CH_PERCENT;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
		q.insert(q.size(), b);
	endfunction

	// mostly well-formed escapes with random content, some cut short
	task automatic send_random_msg();
		logic [7:0] msg[$];
		int         n_tok;
		int         sel;
		int         i;
		n_tok = $urandom_range(1, 6);
		for (i = 0; i < n_tok; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				append_byte(msg, CH_PERCENT);
				append_byte(msg, escape_char());
				append_byte(msg, escape_char());
			end else if (sel < 50) begin
				append_byte(msg, CH_PLUS);
			end else if (sel < 55) begin
				append_byte(msg, CH_PERCENT);
			end else begin
				append_byte(msg, 8'($urandom_range(0, 255)));
			end
		end
		if (msg.size() > 2 && $urandom_range(0, 99) < 15) begin
			void'(msg.pop_back());
			if ($urandom_range(0, 1)) begin
				void'(msg.pop_back());
			end
		end
		for (i = 0; i < msg.size(); i++) begin
			push_byte(msg[i], i == msg.size() - 1);
		end
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((rx.valid && rx.ready) || (tx.valid && tx.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("url_percent_decoder_core test failed");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		rx.valid   = 1'b0;
		rx.in_byte = 8'h00;
		rx.in_last = 1'b0;
		tx.ready   = 1'b0;
		stall_en   = 1'b1;
		items_sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		send_text("+");
		send_text("%");
		send_text("%+");
		send_text("%4a");
		send_text("%-5");
		send_text("%\tc");
		send_text("%+F");
		send_text("%0x");
		send_text("%zz");
		push_byte(CH_PERCENT, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte("7", 1'b1);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			stall_en = !(items_sent >= 700 && items_sent < 1100);
			send_random_msg();
		end
		rx.valid <= 1'b0;
		stall_en = 1'b1;

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("url_percent_decoder_core test passed");
		end else begin
			$display("url_percent_decoder_core test failed");
		end
		$finish;
	end

endmodule
